### rtl/hsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg
// Widths, constants, stage payload types and the hue term function shared by
// the HSL to RGB conversion pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

   localparam int HUE_W    = 9;
   localparam int BYTE_W   = 8;
   localparam int TERM_W   = 7;
   localparam int MIN_W    = 7;
   localparam int SM_W     = 15;
   localparam int LS_W     = 21;
   localparam int NUM_W    = 23;
   localparam int DENOM_W  = 13;
   localparam int RECIP_W  = 20;
   localparam int RED_W    = 21;
   localparam int PROD_W   = RED_W + RECIP_W;
   localparam int RECIP_SHIFT = 32;
   localparam int NUM_CH   = 3;

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   localparam logic [HUE_W:0] OFS_RED   = 10'd0;
   localparam logic [HUE_W:0] OFS_GREEN = 10'd240;
   localparam logic [HUE_W:0] OFS_BLUE  = 10'd120;
   localparam logic [HUE_W:0] HUE_WRAP  = 10'd360;
   localparam logic [HUE_W:0] HUE_WRAP2 = 10'd720;

   localparam logic signed [HUE_W+1:0] RISE_AT = 11'sd90;
   localparam logic signed [HUE_W+1:0] FALL_AT = 11'sd270;
   localparam logic signed [HUE_W+1:0] TERM_MAX = 11'sd30;

   localparam logic [BYTE_W-1:0]   BYTE_MAX = 8'd255;
   localparam logic [DENOM_W-1:0]  DENOM    = 13'd7650;
   localparam logic [RECIP_W-1:0]  RECIP    = 20'd561433;
   localparam logic signed [NUM_W-1:0] SAT_NUM = 23'sd1958400;

   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [NUM_W-1:0]  num_type;

   typedef struct packed {
      term_type [NUM_CH-1:0] term;
      logic [MIN_W-1:0]      min_l;
      logic [BYTE_W-1:0]     sat;
      logic [BYTE_W-1:0]     lit;
      logic [BYTE_W-1:0]     alpha;
   } front_type;

   typedef struct packed {
      term_type [NUM_CH-1:0] term;
      logic [SM_W-1:0]       sm;
      logic [LS_W-1:0]       lit_scaled;
      logic [BYTE_W-1:0]     alpha;
   } prod_type;

   typedef struct packed {
      num_type [NUM_CH-1:0] num;
      logic [BYTE_W-1:0]    alpha;
   } numer_type;

   typedef struct packed {
      logic [RED_W-1:0]  rem_num;
      logic [BYTE_W-1:0] q0;
      logic              zero;
      logic              sat_hi;
   } quot_ch_type;

   typedef struct packed {
      quot_ch_type [NUM_CH-1:0] ch;
      logic [BYTE_W-1:0]        alpha;
   } quot_type;

   typedef struct packed {
      logic [NUM_CH-1:0][BYTE_W-1:0] rgb;
      logic [BYTE_W-1:0]             alpha;
   } pixel_type;

   function automatic term_type hue_term(input logic [HUE_W-1:0] hue,
                                         input logic [HUE_W:0] offset);
      logic [HUE_W:0]          sum;
      logic [HUE_W:0]          k;
      logic signed [HUE_W+1:0] t;
      logic signed [HUE_W+1:0] u;
      sum = {1'b0, hue} + offset;
      if (sum >= HUE_WRAP2) begin
         k = sum - HUE_WRAP2;
      end else if (sum >= HUE_WRAP) begin
         k = sum - HUE_WRAP;
      end else begin
         k = sum;
      end
      t = $signed({1'b0, k}) - RISE_AT;
      u = FALL_AT - $signed({1'b0, k});
      if (u < t) t = u;
      if (t > TERM_MAX) t = TERM_MAX;
      if (t < -TERM_MAX) t = -TERM_MAX;
      return t[TERM_W-1:0];
   endfunction

endpackage

### rtl/hsl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_front
// First stage: wraps the hue per channel into its clamp term and forms
// min(l, 1-l) from the lightness byte.
// ----------------------------------------------------------------------------
module hsl_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [hsl_pkg::HUE_W-1:0]   in_hue,
   input  logic [hsl_pkg::BYTE_W-1:0]  in_sat,
   input  logic [hsl_pkg::BYTE_W-1:0]  in_lit,
   input  logic [hsl_pkg::BYTE_W-1:0]  in_alpha,
   output logic                        out_valid,
   input  logic                        out_ready,
   output hsl_pkg::front_type          out_data
);
   import hsl_pkg::*;

   logic      valid_ff;
   front_type data_ff;
   front_type data_in;
   logic [BYTE_W-1:0] lit_inv;

   assign in_ready = !valid_ff || out_ready;
   assign lit_inv  = BYTE_MAX - in_lit;

   always_comb begin
      data_in.term[CH_RED]   = hue_term(in_hue, OFS_RED);
      data_in.term[CH_GREEN] = hue_term(in_hue, OFS_GREEN);
      data_in.term[CH_BLUE]  = hue_term(in_hue, OFS_BLUE);
      data_in.min_l = (in_lit < lit_inv) ? in_lit[MIN_W-1:0] : lit_inv[MIN_W-1:0];
      data_in.sat   = in_sat;
      data_in.lit   = in_lit;
      data_in.alpha = in_alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### rtl/hsl_numer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_numer
// Two stages: s*m and 7650*l, then the signed numerator 7650*l - s*m*F
// for each channel.
// ----------------------------------------------------------------------------
module hsl_numer (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsl_pkg::front_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsl_pkg::numer_type  out_data
);
   import hsl_pkg::*;

   logic      prod_valid_ff;
   prod_type  prod_ff;
   prod_type  prod_in;
   logic      prod_ready;
   logic      num_valid_ff;
   numer_type num_ff;
   numer_type num_in;
   num_type   part [NUM_CH];

   assign prod_ready = !num_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   always_comb begin
      prod_in.term       = in_data.term;
      prod_in.sm         = SM_W'(in_data.sat) * SM_W'(in_data.min_l);
      prod_in.lit_scaled = LS_W'(in_data.lit) * LS_W'(DENOM);
      prod_in.alpha      = in_data.alpha;
   end

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         part[i]       = $signed({1'b0, prod_ff.sm}) * prod_ff.term[i];
         num_in.num[i] = $signed({2'b00, prod_ff.lit_scaled}) - part[i];
      end
      num_in.alpha = prod_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         num_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (prod_ready) begin
            num_valid_ff <= prod_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (prod_ready && prod_valid_ff) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = num_valid_ff;
   assign out_data  = num_ff;
endmodule

### rtl/hsl_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_scale
// Two stages: reciprocal estimate of numerator / 7650 with range flags,
// then a one-step remainder correction and saturation to a byte.
// ----------------------------------------------------------------------------
module hsl_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  hsl_pkg::numer_type  in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output hsl_pkg::pixel_type  out_data
);
   import hsl_pkg::*;

   logic      quot_valid_ff;
   quot_type  quot_ff;
   quot_type  quot_in;
   logic      quot_ready;
   logic      pix_valid_ff;
   pixel_type pix_ff;
   pixel_type pix_in;
   logic [PROD_W-1:0] prod [NUM_CH];
   logic [RED_W-1:0]  back [NUM_CH];
   logic [RED_W-1:0]  rem  [NUM_CH];
   logic [BYTE_W-1:0] quo  [NUM_CH];

   assign quot_ready = !pix_valid_ff || out_ready;
   assign in_ready   = !quot_valid_ff || quot_ready;

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         prod[i] = PROD_W'(in_data.num[i][RED_W-1:0]) * PROD_W'(RECIP);
         quot_in.ch[i].rem_num = in_data.num[i][RED_W-1:0];
         quot_in.ch[i].q0      = prod[i][RECIP_SHIFT +: BYTE_W];
         quot_in.ch[i].zero    = in_data.num[i][NUM_W-1];
         quot_in.ch[i].sat_hi  = !in_data.num[i][NUM_W-1] && (in_data.num[i] >= SAT_NUM);
      end
      quot_in.alpha = in_data.alpha;
   end

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         back[i] = RED_W'(quot_ff.ch[i].q0) * RED_W'(DENOM);
         rem[i]  = quot_ff.ch[i].rem_num - back[i];
         quo[i]  = (rem[i] >= RED_W'(DENOM)) ? quot_ff.ch[i].q0 + 8'd1 : quot_ff.ch[i].q0;
         if (quot_ff.ch[i].zero) begin
            pix_in.rgb[i] = '0;
         end else if (quot_ff.ch[i].sat_hi) begin
            pix_in.rgb[i] = BYTE_MAX;
         end else begin
            pix_in.rgb[i] = quo[i];
         end
      end
      pix_in.alpha = quot_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            quot_valid_ff <= in_valid;
         end
         if (quot_ready) begin
            pix_valid_ff <= quot_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         quot_ff <= quot_in;
      end
      if (quot_ready && quot_valid_ff) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = pix_valid_ff;
   assign out_data  = pix_ff;
endmodule

### rtl/hsl_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to RGB color conversion, one pixel per clock while the response side is not stalled.
// ----------------------------------------------------------------------------
// A five-stage pipeline that accepts one pixel every clock unless the output
// stalls: hue wrap and clamp terms, s*m and 7650*l products, the signed
// numerator per channel, a reciprocal estimate of the divide by 7650, and a
// remainder correction with byte saturation. Each stage holds its own valid
// bit and takes a new pixel whenever it is empty or its successor moves, so a
// stalled response only backs up as far as the stages that are full. Hue
// values 360 to 511 wrap modulo 360. Alpha passes through unchanged.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hsl_pkg::HUE_W-1:0]   req_hue,
   input  logic [hsl_pkg::BYTE_W-1:0]  req_saturation,
   input  logic [hsl_pkg::BYTE_W-1:0]  req_lightness,
   input  logic [hsl_pkg::BYTE_W-1:0]  req_alpha_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hsl_pkg::BYTE_W-1:0]  rsp_red,
   output logic [hsl_pkg::BYTE_W-1:0]  rsp_green,
   output logic [hsl_pkg::BYTE_W-1:0]  rsp_blue,
   output logic [hsl_pkg::BYTE_W-1:0]  rsp_alpha_out
);
   import hsl_pkg::*;

   logic      front_valid;
   logic      front_ready;
   front_type front_data;
   logic      numer_valid;
   logic      numer_ready;
   numer_type numer_data;
   pixel_type pix_data;

   hsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_lit    (req_lightness),
      .in_alpha  (req_alpha_in),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   hsl_numer u_numer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (numer_valid),
      .out_ready (numer_ready),
      .out_data  (numer_data)
   );

   hsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (numer_valid),
      .in_ready  (numer_ready),
      .in_data   (numer_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (pix_data)
   );

   assign rsp_red       = pix_data.rgb[CH_RED];
   assign rsp_green     = pix_data.rgb[CH_GREEN];
   assign rsp_blue      = pix_data.rgb[CH_BLUE];
   assign rsp_alpha_out = pix_data.alpha;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with an empty output stage");

   a_ready_follows_sink: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while the response side drains");

   a_fill_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
endmodule
